// File: rtl/core/irpd_pkg.sv
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants of the infrared pulse-distance frame encoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Field widths of the channels and registers.
    localparam int CODE_W   = 48;
    localparam int MARK_W   = 16;
    localparam int SPACE_W  = 24;
    localparam int TIMES_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int FLEN_W   = 24;
    localparam int REPEAT_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Default for the largest number of code bits per frame.
    localparam int MAX_BITS_DEFAULT = 48;

    // Reset value of the bit count register.
    localparam logic [COUNT_W-1:0] BIT_COUNT_RESET = 6'd32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_TIMES = 3'd0,
        REG_ONE_TIMES    = 3'd1,
        REG_ZERO_TIMES   = 3'd2,
        REG_FOOTER_TIMES = 3'd3,
        REG_BIT_COUNT    = 3'd4,
        REG_FRAME_LENGTH = 3'd5,
        REG_REPEAT_TIMES = 3'd6
    } reg_index_t;

    // Frame sequencer states.
    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_HEADER   = 7'b0000010,
        ST_BITS     = 7'b0000100,
        ST_FOOT_SUM = 7'b0001000,
        ST_FOOTER   = 7'b0010000,
        ST_REPEAT0  = 7'b0100000,
        ST_REPEAT1  = 7'b1000000
    } state_t;

endpackage

// File: rtl/core/irpd_if.sv
// ----------------------------------------------------------------------------
// irpd_if
// Valid/ready channels of the encoder: code item, duration pair, register write.
// ----------------------------------------------------------------------------

// Code item channel.
interface irpd_item_if;
    logic                          valid;
    logic                          ready;
    logic [irpd_pkg::CODE_W-1:0]   code_word;
    logic                          repeat_request;

    modport source (output valid, output code_word, output repeat_request, input ready);
    modport sink   (input valid, input code_word, input repeat_request, output ready);
endinterface

// Duration pair channel.
interface irpd_pair_if;
    logic                          valid;
    logic                          ready;
    logic [irpd_pkg::MARK_W-1:0]   mark_time;
    logic [irpd_pkg::SPACE_W-1:0]  space_time;
    logic                          last_pair;

    modport source (output valid, output mark_time, output space_time, output last_pair,
                    input ready);
    modport sink   (input valid, input mark_time, input space_time, input last_pair,
                    output ready);
endinterface

// Register write channel.
interface irpd_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [irpd_pkg::CFG_IDX_W-1:0]   index;
    logic [irpd_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/ir_pulse_distance_encoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder
// Turns a code word into an infrared frame of (mark, space) duration pairs.
// ----------------------------------------------------------------------------
// Each accepted code item produces one frame on the pair channel, one beat per
// pair. A normal frame sends the header pair and the code bit pairs, then the
// footer sum state adds the footer mark without a beat, then the footer pair
// goes out; a repeat frame is two pairs. The item channel is ready only while
// the sequencer is idle; it returns to ready as the final pair enters the output
// register, so the next item is taken while that pair still waits. A single
// 25-bit adder/subtractor is shared by the sequencer: it accumulates the frame
// duration and finally forms the saturated remainder of frame_length. Register
// writes are always accepted and must only be made while no frame is active.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder #(
    parameter int MAX_BITS = irpd_pkg::MAX_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    irpd_item_if.sink           item,
    irpd_pair_if.source         pair,
    irpd_cfg_if.sink            cfg
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam int SUM_W = irpd_pkg::SPACE_W;

    // Configuration registers.
    logic [irpd_pkg::TIMES_W-1:0]  header_times_reg;
    logic [irpd_pkg::TIMES_W-1:0]  one_times_reg;
    logic [irpd_pkg::TIMES_W-1:0]  zero_times_reg;
    logic [irpd_pkg::TIMES_W-1:0]  footer_times_reg;
    logic [irpd_pkg::COUNT_W-1:0]  bit_count_reg;
    logic [irpd_pkg::FLEN_W-1:0]   frame_length_reg;
    logic [irpd_pkg::REPEAT_W-1:0] repeat_times_reg;

    // Sequencer state.
    irpd_pkg::state_t              state_reg, state_next;
    logic [irpd_pkg::CODE_W-1:0]   code_shift_reg, code_shift_next;
    logic [CNT_W-1:0]              bits_left_reg, bits_left_next;
    logic [SUM_W-1:0]              duration_sum_reg, duration_sum_next;

    // Output register.
    logic                          out_valid_reg, out_valid_next;
    logic [irpd_pkg::MARK_W-1:0]   out_mark_reg, out_mark_next;
    logic [irpd_pkg::SPACE_W-1:0]  out_space_reg, out_space_next;
    logic                          out_last_reg, out_last_next;

    logic                          item_beat;
    logic                          slot_free;
    logic                          repeat_mode;
    logic [CNT_W-1:0]              bits_start;
    logic [6:0]                    bit_pos;
    logic                          code_bit;
    logic [irpd_pkg::TIMES_W-1:0]  bit_times;
    logic [irpd_pkg::TIMES_W-1:0]  pair_times;
    logic [irpd_pkg::MARK_W:0]     pair_total;

    // Shared adder/subtractor.
    logic [SUM_W-1:0]              alu_a;
    logic [SUM_W-1:0]              alu_b;
    logic                          alu_sub;
    logic [SUM_W:0]                alu_result;

    // Register writes are taken at any time.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_times_reg <= '0;
            one_times_reg    <= '0;
            zero_times_reg   <= '0;
            footer_times_reg <= '0;
            bit_count_reg    <= irpd_pkg::BIT_COUNT_RESET;
            frame_length_reg <= '0;
            repeat_times_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                irpd_pkg::REG_HEADER_TIMES: header_times_reg <= cfg.data[irpd_pkg::TIMES_W-1:0];
                irpd_pkg::REG_ONE_TIMES:    one_times_reg    <= cfg.data[irpd_pkg::TIMES_W-1:0];
                irpd_pkg::REG_ZERO_TIMES:   zero_times_reg   <= cfg.data[irpd_pkg::TIMES_W-1:0];
                irpd_pkg::REG_FOOTER_TIMES: footer_times_reg <= cfg.data[irpd_pkg::TIMES_W-1:0];
                irpd_pkg::REG_BIT_COUNT:    bit_count_reg    <= cfg.data[irpd_pkg::COUNT_W-1:0];
                irpd_pkg::REG_FRAME_LENGTH: frame_length_reg <= cfg.data[irpd_pkg::FLEN_W-1:0];
                irpd_pkg::REG_REPEAT_TIMES: repeat_times_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    // Handshake decode.
    assign item.ready  = (state_reg == irpd_pkg::ST_IDLE);
    assign item_beat   = item.valid && item.ready;
    assign slot_free   = !out_valid_reg || pair.ready;
    assign repeat_mode = item.repeat_request && (repeat_times_reg[15:0] != 16'd0);

    // Bit count saturated to the largest supported frame.
    assign bits_start = (bit_count_reg > irpd_pkg::COUNT_W'(MAX_BITS))
                      ? CNT_W'(MAX_BITS) : CNT_W'(bit_count_reg);

    // Current code bit, MSB first; positions beyond the code word read as zero.
    assign bit_pos   = 7'(bits_left_reg) - 7'd1;
    assign code_bit  = (bit_pos < 7'(irpd_pkg::CODE_W)) ? code_shift_reg[bit_pos[5:0]] : 1'b0;
    assign bit_times = code_bit ? one_times_reg : zero_times_reg;

    // Timing word of the pair being sent and its mark plus space.
    assign pair_times = (state_reg == irpd_pkg::ST_HEADER) ? header_times_reg : bit_times;
    assign pair_total = {1'b0, pair_times[15:0]} + {1'b0, pair_times[31:16]};

    // Operand selection for the shared unit.
    always_comb
    begin
        alu_a   = duration_sum_reg;
        alu_b   = SUM_W'(pair_total);
        alu_sub = 1'b0;
        unique case (state_reg)
            irpd_pkg::ST_FOOT_SUM:
            begin
                alu_b = SUM_W'(footer_times_reg[15:0]);
            end
            irpd_pkg::ST_FOOTER:
            begin
                alu_a   = frame_length_reg;
                alu_b   = duration_sum_reg;
                alu_sub = 1'b1;
            end
            default: ;
        endcase
    end

    // A carry out of the subtraction means no borrow.
    assign alu_result = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                      + (SUM_W + 1)'(alu_sub);

    // Frame sequencer: one pair per cycle when the output register has room.
    always_comb
    begin
        state_next        = state_reg;
        code_shift_next   = code_shift_reg;
        bits_left_next    = bits_left_reg;
        duration_sum_next = duration_sum_reg;
        out_valid_next    = out_valid_reg && !pair.ready;
        out_mark_next     = out_mark_reg;
        out_space_next    = out_space_reg;
        out_last_next     = out_last_reg;

        unique case (state_reg)
            irpd_pkg::ST_IDLE:
            begin
                if (item_beat)
                begin
                    code_shift_next   = item.code_word;
                    bits_left_next    = bits_start;
                    duration_sum_next = '0;
                    state_next        = repeat_mode ? irpd_pkg::ST_REPEAT0
                                                    : irpd_pkg::ST_HEADER;
                end
            end
            irpd_pkg::ST_HEADER,
            irpd_pkg::ST_BITS:
            begin
                if (slot_free)
                begin
                    out_valid_next    = 1'b1;
                    out_mark_next     = pair_times[15:0];
                    out_space_next    = SUM_W'(pair_times[31:16]);
                    out_last_next     = 1'b0;
                    duration_sum_next = alu_result[SUM_W-1:0];
                    if (state_reg == irpd_pkg::ST_BITS)
                    begin
                        bits_left_next = bits_left_reg - CNT_W'(1);
                        if (bits_left_reg == CNT_W'(1))
                        begin
                            state_next = irpd_pkg::ST_FOOT_SUM;
                        end
                    end
                    else
                    begin
                        state_next = (bits_left_reg == '0) ? irpd_pkg::ST_FOOT_SUM
                                                           : irpd_pkg::ST_BITS;
                    end
                end
            end
            irpd_pkg::ST_FOOT_SUM:
            begin
                duration_sum_next = alu_result[SUM_W-1:0];
                state_next        = irpd_pkg::ST_FOOTER;
            end
            irpd_pkg::ST_FOOTER:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_mark_next  = footer_times_reg[15:0];
                    out_last_next  = 1'b1;
                    if (frame_length_reg == '0)
                    begin
                        out_space_next = SUM_W'(footer_times_reg[31:16]);
                    end
                    else
                    begin
                        out_space_next = alu_result[SUM_W] ? alu_result[SUM_W-1:0] : '0;
                    end
                    state_next = irpd_pkg::ST_IDLE;
                end
            end
            irpd_pkg::ST_REPEAT0:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_mark_next  = repeat_times_reg[15:0];
                    out_space_next = SUM_W'(repeat_times_reg[31:16]);
                    out_last_next  = 1'b0;
                    state_next     = irpd_pkg::ST_REPEAT1;
                end
            end
            irpd_pkg::ST_REPEAT1:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_mark_next  = repeat_times_reg[47:32];
                    out_space_next = SUM_W'(repeat_times_reg[63:48]);
                    out_last_next  = 1'b1;
                    state_next     = irpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = irpd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irpd_pkg::ST_IDLE;
            bits_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bits_left_reg <= bits_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        code_shift_reg   <= code_shift_next;
        duration_sum_reg <= duration_sum_next;
        out_mark_reg     <= out_mark_next;
        out_space_reg    <= out_space_next;
        out_last_reg     <= out_last_next;
    end

    assign pair.valid      = out_valid_reg;
    assign pair.mark_time  = out_mark_reg;
    assign pair.space_time = out_space_reg;
    assign pair.last_pair  = out_last_reg;

endmodule

// File: rtl/core/irpd_checker.sv
// ----------------------------------------------------------------------------
// irpd_checker
// Port-level checks of the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module irpd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  logic                          pair_valid,
    input  logic                          pair_ready,
    input  logic [irpd_pkg::MARK_W-1:0]   pair_mark_time,
    input  logic [irpd_pkg::SPACE_W-1:0]  pair_space_time,
    input  logic                          pair_last_pair
);

    // A pair beat stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_ready |=> pair_valid)
    else $error("pair beat withdrawn before it was taken");

    // A stalled pair beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_valid && !pair_ready |=> $stable(pair_mark_time) && $stable(pair_space_time)
                                      && $stable(pair_last_pair))
    else $error("stalled pair beat changed");

    // A code item starts a frame, so the next item waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
    else $error("item channel ready right after a code beat");

    // The encoder turns ready again only as the final pair is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(item_ready) |-> pair_valid && pair_last_pair)
    else $error("item channel ready without a final pair");

endmodule

bind ir_pulse_distance_encoder irpd_checker u_irpd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (item.valid),
    .item_ready      (item.ready),
    .pair_valid      (pair.valid),
    .pair_ready      (pair.ready),
    .pair_mark_time  (pair.mark_time),
    .pair_space_time (pair.space_time),
    .pair_last_pair  (pair.last_pair)
);

// File: tb/tb_ir_pulse_distance_encoder.sv
// ----------------------------------------------------------------------------
// tb_ir_pulse_distance_encoder
// Self-checking bench for the infrared pulse-distance frame encoder. Code items
// go in through a paced sender, and every duration pair coming out is compared
// with a frame that the bench builds itself from its own register copy. The run
// covers directed corner cases and then random configuration phases, with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

// One expected or observed duration pair.
typedef struct packed {
    logic [irpd_pkg::MARK_W-1:0]  mark;
    logic [irpd_pkg::SPACE_W-1:0] space;
    logic                         last;
} ir_pair_t;

// Register copy, frame builder and pair checker.
class frame_scoreboard;
    logic [irpd_pkg::TIMES_W-1:0]  header_times;
    logic [irpd_pkg::TIMES_W-1:0]  one_times;
    logic [irpd_pkg::TIMES_W-1:0]  zero_times;
    logic [irpd_pkg::TIMES_W-1:0]  footer_times;
    logic [irpd_pkg::COUNT_W-1:0]  bit_count;
    logic [irpd_pkg::FLEN_W-1:0]   frame_length;
    logic [irpd_pkg::REPEAT_W-1:0] repeat_times;
    ir_pair_t                      frame_pairs_due[$];
    int unsigned                   mismatches;
    int unsigned                   beats_seen;

    function new();
        header_times = '0;
        one_times    = '0;
        zero_times   = '0;
        footer_times = '0;
        bit_count    = irpd_pkg::BIT_COUNT_RESET;
        frame_length = '0;
        repeat_times = '0;
        mismatches   = 0;
        beats_seen   = 0;
    endfunction

    // Mirror one register write; writes to unknown indexes are dropped.
    function void write_register(logic [irpd_pkg::CFG_IDX_W-1:0] index,
                                 logic [irpd_pkg::CFG_DATA_W-1:0] data);
        case (index)
            irpd_pkg::REG_HEADER_TIMES: header_times = data[irpd_pkg::TIMES_W-1:0];
            irpd_pkg::REG_ONE_TIMES:    one_times    = data[irpd_pkg::TIMES_W-1:0];
            irpd_pkg::REG_ZERO_TIMES:   zero_times   = data[irpd_pkg::TIMES_W-1:0];
            irpd_pkg::REG_FOOTER_TIMES: footer_times = data[irpd_pkg::TIMES_W-1:0];
            irpd_pkg::REG_BIT_COUNT:    bit_count    = data[irpd_pkg::COUNT_W-1:0];
            irpd_pkg::REG_FRAME_LENGTH: frame_length = data[irpd_pkg::FLEN_W-1:0];
            irpd_pkg::REG_REPEAT_TIMES: repeat_times = data[irpd_pkg::REPEAT_W-1:0];
            default:
            begin
            end
        endcase
    endfunction

    function int unsigned pending();
        return frame_pairs_due.size();
    endfunction

    // Queue one mark/space pair taken from a packed timing register and
    // add both durations to the running frame sum, which wraps at 24 bits.
    function void add_timed(logic [irpd_pkg::TIMES_W-1:0] times,
                            inout logic [irpd_pkg::SPACE_W-1:0] sum);
        ir_pair_t p;
        p.mark  = times[15:0];
        p.space = {8'h00, times[31:16]};
        p.last  = 1'b0;
        frame_pairs_due.push_back(p);
        sum = sum + times[15:0] + times[31:16];
    endfunction

    // Build the whole frame that one accepted code item must produce.
    function void add_frame(logic [irpd_pkg::CODE_W-1:0] code, logic rep);
        ir_pair_t                     p;
        logic [irpd_pkg::SPACE_W-1:0] sum;
        int                           nbits;
        // A repeat frame is the four stored durations as two pairs.
        if (rep && repeat_times[15:0] != '0)
        begin
            p.mark  = repeat_times[15:0];
            p.space = {8'h00, repeat_times[31:16]};
            p.last  = 1'b0;
            frame_pairs_due.push_back(p);
            p.mark  = repeat_times[47:32];
            p.space = {8'h00, repeat_times[63:48]};
            p.last  = 1'b1;
            frame_pairs_due.push_back(p);
            return;
        end
        // Header, then the code bits from the top down, with the count capped.
        if (bit_count > irpd_pkg::MAX_BITS_DEFAULT)
            nbits = irpd_pkg::MAX_BITS_DEFAULT;
        else
            nbits = int'(bit_count);
        sum = '0;
        add_timed(header_times, sum);
        for (int i = nbits - 1; i >= 0; i--)
            add_timed(code[i] ? one_times : zero_times, sum);
        // Footer mark; the space either pads the frame out or is the footer space.
        p.mark = footer_times[15:0];
        sum    = sum + footer_times[15:0];
        if (frame_length == '0)
            p.space = {8'h00, footer_times[31:16]};
        else if (frame_length > sum)
            p.space = frame_length - sum;
        else
            p.space = '0;
        p.last = 1'b1;
        frame_pairs_due.push_back(p);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s at pair %0d: got 0x%0h, expected 0x%0h",
                 field, beats_seen, got, want);
        mismatches++;
    endtask

    // Compare one accepted pair with the oldest one still due.
    task check_pair(logic [irpd_pkg::MARK_W-1:0] mark,
                    logic [irpd_pkg::SPACE_W-1:0] space, logic last);
        ir_pair_t want;
        beats_seen++;
        if (frame_pairs_due.size() == 0)
        begin
            report("unexpected pair", {mark, space, last}, '0);
            return;
        end
        want = frame_pairs_due.pop_front();
        if (mark != want.mark)
            report("mark_time", mark, want.mark);
        if (space != want.space)
            report("space_time", space, want.space);
        if (last != want.last)
            report("last_pair", last, want.last);
    endtask
endclass

module tb_ir_pulse_distance_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int TAIL_CYCLES     = 64;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 58;

    // An index that no register answers to.
    localparam logic [irpd_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned cycle_count = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    logic [3:0]  ready_slot = 4'd0;
    int unsigned max_gap;
    int unsigned max_burst;
    int unsigned burst_left;

    frame_scoreboard sb = new();

    irpd_item_if item_ch ();
    irpd_pair_if pair_ch ();
    irpd_cfg_if  cfg_ch ();

    ir_pulse_distance_encoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .pair  (pair_ch),
        .cfg   (cfg_ch)
    );

    always #(CLK_HALF) clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver backpressure follows a rotating 16-bit pattern.
    always @(posedge clk)
    begin
        ready_slot    <= ready_slot + 4'd1;
        pair_ch.ready <= ready_pattern[ready_slot];
    end

    // Watch all three channels for completed beats.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                sb.add_frame(item_ch.code_word, item_ch.repeat_request);
            if (pair_ch.valid && pair_ch.ready)
                sb.check_pair(pair_ch.mark_time, pair_ch.space_time, pair_ch.last_pair);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_register(cfg_ch.index, cfg_ch.data);
        end
    end

    // Offer one code item, wait for its beat, then maybe leave a gap.
    task automatic send_paced(input logic [irpd_pkg::CODE_W-1:0] code, input logic rep);
        int unsigned gap;
        item_ch.valid          <= 1'b1;
        item_ch.code_word      <= code;
        item_ch.repeat_request <= rep;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, max_gap);
            if (gap != 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, max_burst);
        end
    endtask

    // Stop sending and wait until every pair due has come out.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // One register write beat; valid is left high for a following write.
    task automatic write_reg(input logic [irpd_pkg::CFG_IDX_W-1:0] index,
                             input logic [irpd_pkg::CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Fill the bits above a register's width with random data.
    function automatic logic [63:0] with_noise(logic [63:0] v, int unsigned w);
        logic [63:0] r;
        r = {$urandom, $urandom};
        return (r << w) | (v & ((64'd1 << w) - 64'd1));
    endfunction

    // Write every register, plus a stray write to the unused index.
    task automatic load_config(input logic [irpd_pkg::TIMES_W-1:0]  hdr,
                               input logic [irpd_pkg::TIMES_W-1:0]  one,
                               input logic [irpd_pkg::TIMES_W-1:0]  zro,
                               input logic [irpd_pkg::TIMES_W-1:0]  ftr,
                               input logic [irpd_pkg::COUNT_W-1:0]  nbits,
                               input logic [irpd_pkg::FLEN_W-1:0]   flen,
                               input logic [irpd_pkg::REPEAT_W-1:0] rpt);
        write_reg(REG_SPARE, {$urandom, $urandom});
        write_reg(irpd_pkg::REG_HEADER_TIMES, with_noise(hdr, irpd_pkg::TIMES_W));
        write_reg(irpd_pkg::REG_ONE_TIMES, with_noise(one, irpd_pkg::TIMES_W));
        write_reg(irpd_pkg::REG_ZERO_TIMES, with_noise(zro, irpd_pkg::TIMES_W));
        write_reg(irpd_pkg::REG_FOOTER_TIMES, with_noise(ftr, irpd_pkg::TIMES_W));
        write_reg(irpd_pkg::REG_BIT_COUNT, with_noise(nbits, irpd_pkg::COUNT_W));
        write_reg(irpd_pkg::REG_FRAME_LENGTH, with_noise(flen, irpd_pkg::FLEN_W));
        write_reg(irpd_pkg::REG_REPEAT_TIMES, rpt);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random timing register value, weighted toward the extremes.
    function automatic logic [irpd_pkg::TIMES_W-1:0] pick_times();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {8'h00, 8'($urandom), 8'h00, 8'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [irpd_pkg::COUNT_W-1:0]  nbits;
        logic [irpd_pkg::FLEN_W-1:0]   flen;
        logic [irpd_pkg::REPEAT_W-1:0] rpt;
        logic [irpd_pkg::CODE_W-1:0]   code;
        int unsigned                   drain_at;

        rst_n                  = 1'b0;
        item_ch.valid          = 1'b0;
        item_ch.code_word      = '0;
        item_ch.repeat_request = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        max_gap                = 0;
        max_burst              = 4;
        burst_left             = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: zero timings, 32 bits, repeats disabled.
        send_paced(48'hFFFF_FFFF_FFFF, 1'b1);
        wait_drained();

        // Typical timings, full 48-bit frames, repeats enabled.
        load_config(32'h1194_2328, 32'h069A_0230, 32'h0230_0230, 32'h0000_0230,
                    6'd48, 24'd0, 64'hFFFF_0230_08CA_2328);
        send_paced(48'h0000_0000_0000, 1'b0);
        send_paced(48'hFFFF_FFFF_FFFF, 1'b0);
        send_paced(48'hAAAA_AAAA_AAAA, 1'b0);
        send_paced(48'h5555_5555_5555, 1'b0);
        send_paced(48'h8000_0000_0000, 1'b0);
        send_paced(48'h0000_0000_0001, 1'b0);
        send_paced(48'({$urandom, $urandom}), 1'b1);
        send_paced(48'h0000_0000_0000, 1'b1);
        wait_drained();

        // No code bits, long frame padding, repeat disabled by a zero first duration.
        load_config(32'h1194_2328, 32'h069A_0230, 32'h0230_0230, 32'hABCD_0230,
                    6'd0, 24'hFFFFFF, 64'h1234_5678_9ABC_0000);
        ready_pattern = 16'h5A5A;
        max_gap       = 3;
        send_paced(48'({$urandom, $urandom}), 1'b1);
        send_paced(48'({$urandom, $urandom}), 1'b0);
        send_paced(48'({$urandom, $urandom}), 1'b1);
        wait_drained();

        // Oversized bit count, all-ones timings and a frame length that overruns.
        load_config('1, '1, '1, '1, 6'd63, 24'd1000, '1);
        ready_pattern = 16'h0101;
        send_paced(48'hFFFF_FFFF_FFFF, 1'b0);
        send_paced(48'h0000_0000_0000, 1'b0);
        send_paced(48'({$urandom, $urandom}), 1'b1);
        wait_drained();

        // Single bit, zero timings, minimum frame length.
        load_config('0, '0, '0, '0, 6'd1, 24'd1, 64'h0000_0000_0000_0001);
        ready_pattern = 16'hFFFF;
        max_gap       = 0;
        send_paced(48'h0000_0000_0001, 1'b0);
        send_paced(48'h0000_0000_0000, 1'b0);
        send_paced(48'h0000_0000_0000, 1'b1);
        wait_drained();

        // Random phases, each with its own configuration and pacing.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case ($urandom_range(0, 7))
                0: nbits = '0;
                1: nbits = 6'd1;
                2: nbits = 6'($urandom_range(49, 63));
                3: nbits = 6'd48;
                default: nbits = 6'($urandom_range(2, 47));
            endcase
            case ($urandom_range(0, 3))
                0: flen = '0;
                1: flen = '1;
                2: flen = 24'($urandom_range(1, 24'h1FFFFF));
                default: flen = 24'($urandom);
            endcase
            rpt = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0)
                rpt[15:0] = '0;
            else if ($urandom_range(0, 5) == 0)
                rpt = '1;
            else if (rpt[15:0] == '0)
                rpt[0] = 1'b1;
            load_config(pick_times(), pick_times(), pick_times(), pick_times(),
                        nbits, flen, rpt);

            case (ph % 4)
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom) | 16'h0001;
                2: ready_pattern = 16'h0101;
                default: ready_pattern = 16'($urandom) | 16'h8000;
            endcase
            max_gap   = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
            max_burst = $urandom_range(1, 16);
            drain_at  = $urandom_range(1, ITEMS_PER_PHASE - 1);

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Once per phase the sender holds off until the block is empty.
                if (n == drain_at)
                    wait_drained();
                case ($urandom_range(0, 9))
                    0: code = '0;
                    1: code = '1;
                    default: code = 48'({$urandom, $urandom});
                endcase
                send_paced(code, $urandom_range(0, 3) == 0);
            end
            wait_drained();
        end

        // Let any stray pairs show up before deciding.
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/irpd_pkg.sv
rtl/core/irpd_if.sv
rtl/core/ir_pulse_distance_encoder.sv
rtl/core/irpd_checker.sv
tb/tb_ir_pulse_distance_encoder.sv
